// ===== hdl/wavhp_pkg.sv =====
// shared types and status codes for the wav header parser
// no dependencies; used by wavhp_parser and wav_header_parser_top
package wavhp_pkg;

  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_TOO_SMALL     = 4'd1;
  localparam logic [3:0] ST_BAD_RIFF      = 4'd2;
  localparam logic [3:0] ST_CHUNK_OUTSIDE = 4'd3;
  localparam logic [3:0] ST_BAD_FMT       = 4'd4;
  localparam logic [3:0] ST_NOT_PCM       = 4'd5;
  localparam logic [3:0] ST_MISSING       = 4'd6;
  localparam logic [3:0] ST_UNSUPPORTED   = 4'd7;
  localparam logic [3:0] ST_INCONSISTENT  = 4'd8;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [1:0]  channels;
    logic [31:0] sample_rate;
    logic [31:0] data_start;
    logic [31:0] data_length;
  } result_t;

endpackage

// ===== hdl/wavhp_parser.sv =====
// parse state and per-byte update of the riff/wave chunk walk, plus final status
// depends on wavhp_pkg
module wavhp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  wavhp_pkg::item_t  item,
  input  logic [31:0]       file_length,
  output wavhp_pkg::result_t parsed
);

  typedef enum logic [2:0] {
    PH_RIFF, PH_RLEN, PH_WAVE, PH_HDR, PH_FMT, PH_SKIP, PH_DONE
  } phase_t;

  localparam logic [31:0] TAG_RIFF     = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE     = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT      = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA     = 32'h6461_7461;
  localparam logic [33:0] RIFF_HDR_LEN = 34'd12;
  localparam logic [31:0] FMT_MIN_LEN  = 32'd16;

  phase_t      phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] length_accumulator, length_accumulator_next;
  logic [32:0] riff_end, riff_end_next;
  logic [31:0] chunk_start, chunk_start_next;
  logic [32:0] skip_until, skip_until_next;
  logic [7:0]  fmt_bytes [16];
  logic [7:0]  fmt_bytes_next [16];
  logic [31:0] data_start, data_start_next;
  logic [31:0] data_length, data_length_next;
  logic        seen_fmt, seen_fmt_next;
  logic        seen_data, seen_data_next;
  logic [3:0]  error_code, error_code_next;

  logic [7:0]  b;
  logic [2:0]  off;
  logic [3:0]  k;
  logic [31:0] tag_shifted;
  logic [31:0] len_shifted;
  logic [31:0] len_sel;
  logic [33:0] nxt_chunk;
  logic [33:0] nxt_sel;
  logic [34:0] nxt_end;
  logic [32:0] pos_plus1;
  logic [32:0] room;
  logic [32:0] rlen_end;
  phase_t      go_phase;
  logic [31:0] go_cs;
  logic [32:0] go_su;

  logic [3:0]  st;
  logic [15:0] ch, bits, align;
  logic [31:0] rate, brate;
  logic [33:0] rate_x;
  logic        mod_bad;

  assign b = item.file_byte;

  // shared chunk-advance logic
  always_comb begin
    off         = byte_position[2:0] - chunk_start[2:0];
    k           = byte_position[3:0] - chunk_start[3:0];
    tag_shifted = {tag_shift[23:0], b};
    len_shifted = {b, length_accumulator[31:8]};
    len_sel     = (phase == PH_HDR) ? len_shifted : length_accumulator;
    nxt_chunk   = {2'b0, chunk_start} + {2'b0, len_sel} + {33'b0, len_sel[0]};
    case (phase)
      PH_WAVE: nxt_sel = RIFF_HDR_LEN;
      PH_SKIP: nxt_sel = {1'b0, skip_until};
      default: nxt_sel = nxt_chunk;
    endcase
    nxt_end   = {1'b0, nxt_sel} + 35'd8;
    pos_plus1 = {1'b0, byte_position} + 33'd1;
    room      = riff_end - {1'b0, chunk_start};
    rlen_end  = {1'b0, len_shifted} + 33'd8;
    go_cs     = nxt_end[31:0];
    go_su     = nxt_sel[32:0];
    if (nxt_end > {2'b0, riff_end}) begin
      go_phase = PH_DONE;
    end else if (nxt_sel == {1'b0, pos_plus1}) begin
      go_phase = PH_HDR;
    end else begin
      go_phase = PH_SKIP;
    end
  end

  always_comb begin
    phase_next              = phase;
    tag_shift_next          = tag_shift;
    length_accumulator_next = length_accumulator;
    riff_end_next           = riff_end;
    chunk_start_next        = chunk_start;
    skip_until_next         = skip_until;
    fmt_bytes_next          = fmt_bytes;
    data_start_next         = data_start;
    data_length_next        = data_length;
    seen_fmt_next           = seen_fmt;
    seen_data_next          = seen_data;
    error_code_next         = error_code;
    byte_position_next      = (byte_position == '1) ? byte_position : byte_position + 32'd1;

    if (error_code == wavhp_pkg::ST_OK) begin
      unique case (phase)
        PH_RIFF: begin
          if (byte_position == 32'd0 && file_length < 32'd12) begin
            error_code_next = wavhp_pkg::ST_TOO_SMALL;
          end else begin
            tag_shift_next = tag_shifted;
            if (byte_position == 32'd3) begin
              if (tag_shifted != TAG_RIFF) begin
                error_code_next = wavhp_pkg::ST_BAD_RIFF;
              end else begin
                phase_next = PH_RLEN;
              end
            end
          end
        end
        PH_RLEN: begin
          length_accumulator_next = len_shifted;
          if (byte_position == 32'd7) begin
            if (rlen_end > {1'b0, file_length}) begin
              error_code_next = wavhp_pkg::ST_BAD_RIFF;
            end else begin
              riff_end_next = rlen_end;
              phase_next    = PH_WAVE;
            end
          end
        end
        PH_WAVE: begin
          tag_shift_next = tag_shifted;
          if (byte_position == 32'd11) begin
            if (tag_shifted != TAG_WAVE) begin
              error_code_next = wavhp_pkg::ST_BAD_RIFF;
            end else begin
              phase_next       = go_phase;
              chunk_start_next = (go_phase == PH_HDR) ? go_cs : chunk_start;
              skip_until_next  = (go_phase == PH_SKIP) ? go_su : skip_until;
            end
          end
        end
        PH_HDR: begin
          if (off < 3'd4) begin
            tag_shift_next = tag_shifted;
          end else begin
            length_accumulator_next = len_shifted;
          end
          if (off == 3'd7) begin
            if ({1'b0, len_shifted} > room) begin
              error_code_next = wavhp_pkg::ST_CHUNK_OUTSIDE;
            end else if (tag_shift == TAG_FMT) begin
              if (len_shifted < FMT_MIN_LEN) begin
                error_code_next = wavhp_pkg::ST_BAD_FMT;
              end else begin
                phase_next = PH_FMT;
              end
            end else begin
              if (tag_shift == TAG_DATA) begin
                data_start_next  = chunk_start;
                data_length_next = len_shifted;
                seen_data_next   = 1'b1;
              end
              if (nxt_sel > {1'b0, riff_end}) begin
                error_code_next = wavhp_pkg::ST_CHUNK_OUTSIDE;
              end else begin
                phase_next       = go_phase;
                chunk_start_next = (go_phase == PH_HDR) ? go_cs : chunk_start;
                skip_until_next  = (go_phase == PH_SKIP) ? go_su : skip_until;
              end
            end
          end
        end
        PH_FMT: begin
          fmt_bytes_next[k] = b;
          if (k == 4'd15) begin
            if ({fmt_bytes[1], fmt_bytes[0]} != 16'd1) begin
              error_code_next = wavhp_pkg::ST_NOT_PCM;
            end else begin
              seen_fmt_next = 1'b1;
              if (nxt_sel > {1'b0, riff_end}) begin
                error_code_next = wavhp_pkg::ST_CHUNK_OUTSIDE;
              end else begin
                phase_next       = go_phase;
                chunk_start_next = (go_phase == PH_HDR) ? go_cs : chunk_start;
                skip_until_next  = (go_phase == PH_SKIP) ? go_su : skip_until;
              end
            end
          end
        end
        PH_SKIP: begin
          if (pos_plus1 == skip_until) begin
            phase_next       = go_phase;
            chunk_start_next = (go_phase == PH_HDR) ? go_cs : chunk_start;
            skip_until_next  = (go_phase == PH_SKIP) ? go_su : skip_until;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // final status from the state after this byte
  always_comb begin
    ch       = {fmt_bytes_next[3], fmt_bytes_next[2]};
    rate     = {fmt_bytes_next[7], fmt_bytes_next[6], fmt_bytes_next[5], fmt_bytes_next[4]};
    brate    = {fmt_bytes_next[11], fmt_bytes_next[10], fmt_bytes_next[9], fmt_bytes_next[8]};
    align    = {fmt_bytes_next[13], fmt_bytes_next[12]};
    bits     = {fmt_bytes_next[15], fmt_bytes_next[14]};
    rate_x   = (ch == 16'd1) ? {1'b0, rate, 1'b0} : {rate, 2'b0};
    mod_bad  = (ch == 16'd1) ? data_length_next[0] : (|data_length_next[1:0]);
    if (error_code_next != wavhp_pkg::ST_OK) begin
      st = error_code_next;
    end else if (phase_next != PH_DONE) begin
      if (phase_next == PH_RIFF || phase_next == PH_RLEN || phase_next == PH_WAVE) begin
        st = wavhp_pkg::ST_BAD_RIFF;
      end else if (phase_next == PH_FMT) begin
        st = wavhp_pkg::ST_NOT_PCM;
      end else begin
        st = wavhp_pkg::ST_CHUNK_OUTSIDE;
      end
    end else if (!(seen_fmt_next && seen_data_next)) begin
      st = wavhp_pkg::ST_MISSING;
    end else if (ch < 16'd1 || ch > 16'd2 || bits != 16'd16) begin
      st = wavhp_pkg::ST_UNSUPPORTED;
    end else if (align != {ch[14:0], 1'b0} || {2'b0, brate} != rate_x ||
                 data_length_next == 32'd0 || mod_bad) begin
      st = wavhp_pkg::ST_INCONSISTENT;
    end else begin
      st = wavhp_pkg::ST_OK;
    end
    parsed.status = st;
    if (st == wavhp_pkg::ST_OK) begin
      parsed.channels    = ch[1:0];
      parsed.sample_rate = rate;
      parsed.data_start  = data_start_next;
      parsed.data_length = data_length_next;
    end else begin
      parsed.channels    = '0;
      parsed.sample_rate = '0;
      parsed.data_start  = '0;
      parsed.data_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_RIFF;
      byte_position <= '0;
      seen_fmt      <= 1'b0;
      seen_data     <= 1'b0;
      error_code    <= wavhp_pkg::ST_OK;
    end else if (step) begin
      if (item.last) begin
        phase         <= PH_RIFF;
        byte_position <= '0;
        seen_fmt      <= 1'b0;
        seen_data     <= 1'b0;
        error_code    <= wavhp_pkg::ST_OK;
      end else begin
        phase         <= phase_next;
        byte_position <= byte_position_next;
        seen_fmt      <= seen_fmt_next;
        seen_data     <= seen_data_next;
        error_code    <= error_code_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tag_shift          <= tag_shift_next;
      length_accumulator <= length_accumulator_next;
      riff_end           <= riff_end_next;
      chunk_start        <= chunk_start_next;
      skip_until         <= skip_until_next;
      fmt_bytes          <= fmt_bytes_next;
      data_start         <= data_start_next;
      data_length        <= data_length_next;
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (error_code != wavhp_pkg::ST_OK && !(step && item.last)) |=>
      error_code == $past(error_code))
    else $error("error code changed without end of file");

  a_hdr_inside: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HDR || phase == PH_FMT) |-> {1'b0, chunk_start} <= riff_end)
    else $error("chunk payload start beyond riff end");

  a_pos_saturate: assert property (@(posedge clk) disable iff (rst)
    (byte_position == '1 && step && !item.last) |=> byte_position == '1)
    else $error("byte position wrapped");

endmodule

// ===== hdl/wav_header_parser_top.sv =====
// wav header parser top: input register, parser, result register
// depends on wavhp_pkg and wavhp_parser
// a result is registered in the result register once its last item has passed the input register and stepped the parser
// throughput: one item per cycle; the input register stalls only when a
//   last item meets a full, stalled result register
// reset clears the parse phase, byte position, chunk flags, error code and file_length
module wav_header_parser_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               item_valid,
  output logic               item_stall,
  input  wavhp_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output wavhp_pkg::result_t result
);

  logic               hold_valid;
  wavhp_pkg::item_t   hold_item;
  logic               go;
  logic [31:0]        file_length;
  wavhp_pkg::result_t parsed;

  assign go         = hold_valid && (!hold_item.last || !result_valid || !result_stall);
  assign item_stall = hold_valid && !go;

  wavhp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (go),
    .item        (hold_item),
    .file_length (file_length),
    .parsed      (parsed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
      file_length  <= '0;
    end else begin
      if (cfg_we) begin
        file_length <= cfg_wdata;
      end
      if (!hold_valid || go) begin
        hold_valid <= item_valid;
      end
      if (go && hold_item.last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      hold_item <= item;
    end
    if (go && hold_item.last) begin
      result <= parsed;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> hold_valid && hold_item.last && result_valid)
    else $error("stall without a blocked last item");

  a_error_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != wavhp_pkg::ST_OK) |->
      (result.channels == '0 && result.sample_rate == '0 &&
       result.data_start == '0 && result.data_length == '0))
    else $error("fields not cleared on error status");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    ($rose(result_valid)) |-> $past(go && hold_item.last))
    else $error("result without a last item");

endmodule

// ===== tb/sv/wav_header_parser_top_test.sv =====
// testbench for wav_header_parser_top: streams short directed files, then random
// wav files both well formed and broken, and checks every header report
// depends on wavhp_pkg and the wav_header_parser_top rtl
module wav_header_parser_top_test;

  typedef enum logic [2:0] {
    WALK_RIFF, WALK_RLEN, WALK_WAVE, WALK_HDR, WALK_FMT, WALK_SKIP, WALK_DONE
  } walk_t;

  typedef enum int {
    F_OK, F_SHORT_FMT, F_NOT_PCM, F_NO_FMT, F_NO_DATA, F_BAD_CH, F_BAD_BITS,
    F_BAD_ALIGN, F_BAD_RATE, F_ZERO_DATA, F_ODD_DATA, F_BIG_CHUNK, F_PAD_PAST,
    F_SHORT_RIFF, F_HUGE_RIFF, F_TRUNCATE, F_CORRUPT, F_NOISE, F_COUNT
  } flavor_t;

  typedef logic [7:0] octets_t[$];

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
  localparam int RIFF_HDR_LEN = 12;
  localparam int FMT_MIN_LEN  = 16;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [31:0]        cfg_wdata = '0;
  logic               item_valid = 1'b0;
  logic               item_stall;
  wavhp_pkg::item_t   item = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  wavhp_pkg::result_t result;

  // local copy of the parser state
  logic [31:0] file_len;
  logic [31:0] byte_pos;
  walk_t       walk_phase;
  logic [31:0] tag_sr;
  logic [31:0] len_sr;
  logic [63:0] riff_end;
  logic [31:0] chunk_start;
  logic [63:0] skip_to;
  logic [63:0] fmt_w [3];
  logic [63:0] data_loc;
  logic [1:0]  seen;
  logic [3:0]  err;

  wavhp_pkg::result_t header_reports[$];
  wavhp_pkg::item_t   byte_stream[$];
  wavhp_pkg::result_t want_report;
  int          failures = 0;
  int          queued_items = 0;
  int          queued_files = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          idling = 1'b1;

  wav_header_parser_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void clear_parse();
    byte_pos = '0;
    walk_phase = WALK_RIFF;
    tag_sr = '0;
    len_sr = '0;
    riff_end = '0;
    chunk_start = '0;
    skip_to = '0;
    fmt_w[0] = '0;
    fmt_w[1] = '0;
    fmt_w[2] = '0;
    data_loc = '0;
    seen = '0;
    err = wavhp_pkg::ST_OK;
  endfunction

  function automatic void flag(input logic [3:0] code);
    if (err == wavhp_pkg::ST_OK) err = code;
  endfunction

  function automatic void next_chunk(input logic [63:0] at, input logic [63:0] nxt);
    logic [63:0] hdr_end;
    hdr_end = nxt + 64'd8;
    if (hdr_end > riff_end) begin
      walk_phase = WALK_DONE;
    end else if (nxt == at + 64'd1) begin
      walk_phase = WALK_HDR;
      chunk_start = hdr_end[31:0];
    end else begin
      walk_phase = WALK_SKIP;
      skip_to = nxt;
    end
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    logic [63:0] at, off, cs, len, nxt, k;
    int sh, idx, base;
    at = {32'd0, byte_pos};
    cs = {32'd0, chunk_start};
    case (walk_phase)
      WALK_RIFF: begin
        if (at == 0 && file_len < RIFF_HDR_LEN) begin
          flag(wavhp_pkg::ST_TOO_SMALL);
          return;
        end
        tag_sr = {tag_sr[23:0], b};
        if (at == 3) begin
          if (tag_sr != TAG_RIFF) begin
            flag(wavhp_pkg::ST_BAD_RIFF);
            return;
          end
          walk_phase = WALK_RLEN;
        end
      end
      WALK_RLEN: begin
        len_sr = {b, len_sr[31:8]};
        if (at == 7) begin
          len = {32'd0, len_sr} + 64'd8;
          if (len > {32'd0, file_len}) begin
            flag(wavhp_pkg::ST_BAD_RIFF);
            return;
          end
          riff_end = len;
          walk_phase = WALK_WAVE;
        end
      end
      WALK_WAVE: begin
        tag_sr = {tag_sr[23:0], b};
        if (at == 11) begin
          if (tag_sr != TAG_WAVE) begin
            flag(wavhp_pkg::ST_BAD_RIFF);
            return;
          end
          next_chunk(at, 64'(RIFF_HDR_LEN));
        end
      end
      WALK_HDR: begin
        off = at + 64'd8 - cs;
        if (off < 4) tag_sr = {tag_sr[23:0], b};
        else len_sr = {b, len_sr[31:8]};
        if (off == 7) begin
          len = {32'd0, len_sr};
          nxt = cs + len + len[0];
          if (len > riff_end - cs) begin
            flag(wavhp_pkg::ST_CHUNK_OUTSIDE);
            return;
          end
          if (tag_sr == TAG_FMT) begin
            if (len < FMT_MIN_LEN) begin
              flag(wavhp_pkg::ST_BAD_FMT);
              return;
            end
            walk_phase = WALK_FMT;
            return;
          end
          if (tag_sr == TAG_DATA) begin
            data_loc = {len[31:0], chunk_start};
            seen[1] = 1'b1;
          end
          if (nxt > riff_end) begin
            flag(wavhp_pkg::ST_CHUNK_OUTSIDE);
            return;
          end
          next_chunk(at, nxt);
        end
      end
      WALK_FMT: begin
        k = (at - cs) & 64'd15;
        if (k < 4) begin
          idx = 0;
          base = 0;
        end else if (k < 12) begin
          idx = 1;
          base = 4;
        end else begin
          idx = 2;
          base = 12;
        end
        sh = 8 * (int'(k) - base);
        fmt_w[idx][sh +: 8] = b;
        if (k == 15) begin
          len = {32'd0, len_sr};
          nxt = cs + len + len[0];
          if (fmt_w[0][15:0] != 16'd1) begin
            flag(wavhp_pkg::ST_NOT_PCM);
            return;
          end
          seen[0] = 1'b1;
          if (nxt > riff_end) begin
            flag(wavhp_pkg::ST_CHUNK_OUTSIDE);
            return;
          end
          next_chunk(at, nxt);
        end
      end
      WALK_SKIP: begin
        if (at + 64'd1 == skip_to) next_chunk(at, skip_to);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [3:0] header_status();
    logic [15:0] ch, bits, align;
    logic [63:0] rate, brate, dlen, fb;
    if (err != wavhp_pkg::ST_OK) return err;
    if (walk_phase != WALK_DONE) begin
      if (walk_phase <= WALK_WAVE) return wavhp_pkg::ST_BAD_RIFF;
      if (walk_phase == WALK_FMT) return wavhp_pkg::ST_NOT_PCM;
      return wavhp_pkg::ST_CHUNK_OUTSIDE;
    end
    if (seen != 2'b11) return wavhp_pkg::ST_MISSING;
    ch = fmt_w[0][31:16];
    bits = fmt_w[2][31:16];
    align = fmt_w[2][15:0];
    rate = {32'd0, fmt_w[1][31:0]};
    brate = {32'd0, fmt_w[1][63:32]};
    dlen = {32'd0, data_loc[63:32]};
    if (ch < 1 || ch > 2 || bits != 16) return wavhp_pkg::ST_UNSUPPORTED;
    fb = 64'd2 * ch;
    if (align != fb || brate != rate * fb || dlen == 0 || dlen % fb != 0)
      return wavhp_pkg::ST_INCONSISTENT;
    return wavhp_pkg::ST_OK;
  endfunction

  function automatic void accept_item(input wavhp_pkg::item_t it);
    wavhp_pkg::result_t r;
    if (err == wavhp_pkg::ST_OK) take_byte(it.file_byte);
    if (byte_pos != '1) byte_pos = byte_pos + 32'd1;
    if (it.last) begin
      r = '0;
      r.status = header_status();
      if (r.status == wavhp_pkg::ST_OK) begin
        r.channels = fmt_w[0][17:16];
        r.sample_rate = fmt_w[1][31:0];
        r.data_start = data_loc[31:0];
        r.data_length = data_loc[63:32];
      end
      header_reports.push_back(r);
      clear_parse();
    end
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic void put16(ref octets_t q, input logic [15:0] v);
    q.push_back(v[7:0]);
    q.push_back(v[15:8]);
  endfunction

  function automatic void put32(ref octets_t q, input logic [31:0] v);
    put16(q, v[15:0]);
    put16(q, v[31:16]);
  endfunction

  function automatic void put_tag(ref octets_t q, input logic [31:0] t);
    q.push_back(t[31:24]);
    q.push_back(t[23:16]);
    q.push_back(t[15:8]);
    q.push_back(t[7:0]);
  endfunction

  function automatic void put_fill(ref octets_t q, input int n);
    for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_chunk(ref octets_t q, input logic [31:0] tag,
                                    input logic [31:0] len, input int fill, input bit pad);
    put_tag(q, tag);
    put32(q, len);
    put_fill(q, fill);
    if (pad && len[0]) put_fill(q, 1);
  endfunction

  function automatic void add_fmt(ref octets_t q, input logic [31:0] len,
                                  input logic [15:0] enc, input logic [15:0] ch,
                                  input logic [31:0] rate, input logic [31:0] brate,
                                  input logic [15:0] align, input logic [15:0] bits);
    put_tag(q, TAG_FMT);
    put32(q, len);
    if (len < FMT_MIN_LEN) begin
      put_fill(q, len);
    end else begin
      put16(q, enc);
      put16(q, ch);
      put32(q, rate);
      put32(q, brate);
      put16(q, align);
      put16(q, bits);
      put_fill(q, len - FMT_MIN_LEN);
    end
    if (len[0]) put_fill(q, 1);
  endfunction

  function automatic logic [31:0] junk_tag();
    logic [31:0] t;
    t = ($urandom_range(0, 1) == 1) ? TAG_LIST : $urandom;
    if (t == TAG_FMT || t == TAG_DATA) t = t ^ 32'h1;
    return t;
  endfunction

  function automatic void make_file(input flavor_t kind, ref octets_t f);
    octets_t body;
    logic [15:0] ch, bits, align, enc;
    logic [31:0] rate, brate, flen, dlen, rlen;
    int n, at, cut;
    bit data_first;
    ch = 16'($urandom_range(1, 2));
    enc = 16'd1;
    bits = 16'd16;
    align = 16'd2 * ch;
    case ($urandom_range(0, 3))
      0: rate = 32'd44100;
      1: rate = 32'd48000;
      2: rate = $urandom_range(1, 200000);
      default: rate = $urandom_range(1, 32'h3FFF_FFFF);
    endcase
    brate = rate * 2 * ch;
    flen = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 20) : 32'd16;
    dlen = 2 * ch * $urandom_range(1, 6);
    case (kind)
      F_SHORT_FMT: flen = $urandom_range(0, 15);
      F_NOT_PCM: begin
        enc = 16'($urandom);
        if (enc == 16'd1) enc = 16'd0;
      end
      F_BAD_CH: begin
        case ($urandom_range(0, 2))
          0: ch = 16'd0;
          1: ch = 16'd3;
          default: ch = 16'($urandom_range(3, 65535));
        endcase
      end
      F_BAD_BITS: begin
        bits = 16'($urandom);
        if (bits == 16'd16) bits = 16'd8;
      end
      F_BAD_ALIGN: align = align ^ 16'($urandom_range(1, 65535));
      F_BAD_RATE: begin
        if ($urandom_range(0, 1) == 1) begin
          brate = brate ^ (32'd1 << $urandom_range(0, 31));
        end else begin
          // exact byte rate needs more than 32 bits
          rate = 32'h8000_0000 + $urandom_range(0, 65535);
          brate = rate * 2 * ch;
        end
      end
      F_ZERO_DATA: dlen = '0;
      F_ODD_DATA: dlen = 2 * ch * $urandom_range(0, 5) + $urandom_range(1, 2 * ch - 1);
      default: ;
    endcase
    data_first = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(0, 9);
      add_chunk(body, junk_tag(), n, n, 1'b1);
    end
    if (data_first && kind != F_NO_DATA) add_chunk(body, TAG_DATA, dlen, dlen, 1'b1);
    if (kind != F_NO_FMT) add_fmt(body, flen, enc, ch, rate, brate, align, bits);
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(0, 9);
      add_chunk(body, junk_tag(), n, n, 1'b1);
    end
    if (!data_first && kind != F_NO_DATA) add_chunk(body, TAG_DATA, dlen, dlen, 1'b1);
    // a repeated chunk overwrites the earlier one
    if ($urandom_range(0, 7) == 0 && kind != F_NO_DATA)
      add_chunk(body, TAG_DATA, dlen, dlen, 1'b1);
    if ($urandom_range(0, 7) == 0 && kind != F_NO_FMT)
      add_fmt(body, flen, enc, ch, rate, brate, align, bits);
    if (kind == F_BIG_CHUNK) begin
      n = $urandom_range(0, 6);
      if ($urandom_range(0, 1) == 1) add_chunk(body, junk_tag(), n + 1, n, 1'b0);
      else add_chunk(body, junk_tag(), 32'h8000_0000 + $urandom_range(0, 32'h7FFF_FFFF), n, 1'b0);
    end
    if (kind == F_PAD_PAST) begin
      // odd chunk ends exactly at the riff end, its pad byte falls outside
      n = 2 * $urandom_range(0, 4) + 1;
      add_chunk(body, junk_tag(), n, n, 1'b0);
    end
    rlen = body.size() + 4;
    if (kind == F_SHORT_RIFF) rlen = rlen - $urandom_range(1, rlen);
    if (kind == F_HUGE_RIFF) rlen = 32'hFFFF_FFF8 + $urandom_range(0, 7);
    f = {};
    put_tag(f, TAG_RIFF);
    put32(f, rlen);
    put_tag(f, TAG_WAVE);
    foreach (body[i]) f.push_back(body[i]);
    if ($urandom_range(0, 3) == 0) put_fill(f, $urandom_range(1, 6));
    if (kind == F_TRUNCATE) begin
      cut = $urandom_range(1, f.size() - 1);
      while (f.size() > cut) void'(f.pop_back());
    end
    if (kind == F_CORRUPT) begin
      at = $urandom_range(0, ((f.size() < 44) ? f.size() : 44) - 1);
      f[at] = f[at] ^ (8'd1 << $urandom_range(0, 7));
    end
    if (kind == F_NOISE) begin
      f = {};
      put_fill(f, $urandom_range(1, 24));
    end
  endfunction

  function automatic void queue_file(input octets_t f);
    wavhp_pkg::item_t it;
    foreach (f[i]) begin
      it.file_byte = f[i];
      it.last = (i == f.size() - 1);
      byte_stream.push_back(it);
    end
    queued_items += f.size();
    queued_files++;
  endfunction

  task automatic write_length(input logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    file_len = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (byte_stream.size() != 0 || item_valid || header_reports.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item <= '0;
      gap_left = 0;
    end else begin
      if (item_valid && !item_stall) accept_item(item);
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (byte_stream.size() > 0) begin
          item <= byte_stream.pop_front();
          item_valid <= 1'b1;
          if (idling) gap_left = idle_len();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // header report monitor
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (header_reports.size() == 0) begin
          $error("unexpected header report, status %0d", result.status);
          failures++;
        end else begin
          want_report = header_reports.pop_front();
          if (result.status !== want_report.status) begin
            $error("status: expected %0d, got %0d", want_report.status, result.status);
            failures++;
          end
          if (result.channels !== want_report.channels) begin
            $error("channels: expected %0d, got %0d", want_report.channels, result.channels);
            failures++;
          end
          if (result.sample_rate !== want_report.sample_rate) begin
            $error("sample_rate: expected %0d, got %0d",
                   want_report.sample_rate, result.sample_rate);
            failures++;
          end
          if (result.data_start !== want_report.data_start) begin
            $error("data_start: expected %0d, got %0d",
                   want_report.data_start, result.data_start);
            failures++;
          end
          if (result.data_length !== want_report.data_length) begin
            $error("data_length: expected %0d, got %0d",
                   want_report.data_length, result.data_length);
            failures++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
        if (idling) stall_left = idle_len();
      end
    end
  end

  initial begin
    octets_t f;
    flavor_t kind;
    logic [31:0] len_setting;
    int budget_items, budget_files, random_files;
    file_len = '0;
    clear_parse();
    random_files = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // too small, bad tag, last inside the riff header, header only
    write_length(32'd0);
    f = {8'h52};
    queue_file(f);
    f = {8'h00, 8'hFF};
    queue_file(f);
    drain();
    write_length(32'd11);
    f = {8'hFF};
    queue_file(f);
    drain();
    write_length(32'd12);
    f = {8'h52, 8'h49, 8'h46, 8'h58};
    queue_file(f);
    f = {8'h52, 8'h49};
    queue_file(f);
    f = {};
    put_tag(f, TAG_RIFF);
    put32(f, 32'd4);
    put_tag(f, TAG_WAVE);
    queue_file(f);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: len_setting = $urandom_range(12, 60);
        3: len_setting = $urandom_range(61, 200);
        4: len_setting = 32'h8000_0000 + $urandom_range(0, 32'h7FFF_FFFF);
        default: len_setting = 32'hFFFF_FFFF;
      endcase
      idling = (p != 0);
      write_length(len_setting);
      budget_items = queued_items + 280;
      budget_files = queued_files + 4;
      while (queued_items < budget_items || queued_files < budget_files) begin
        if (random_files < F_COUNT) kind = flavor_t'(random_files);
        else if ($urandom_range(0, 2) == 0) kind = F_OK;
        else kind = flavor_t'($urandom_range(0, F_COUNT - 1));
        make_file(kind, f);
        queue_file(f);
        random_files++;
      end
      drain();
    end

    if (failures == 0) begin
      $display("wav_header_parser_top verification clean");
    end else begin
      $display("wav_header_parser_top verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("wav_header_parser_top verification failed");
    $finish;
  end

endmodule
